@@ rtl/ahfhe_pkg.sv @@
package ahfhe_pkg;

	// fixed field widths
	localparam int POS_W    = 32;
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 16;
	localparam int IDX_W    = 8;
	localparam int HEAT_W   = 8;
	localparam int COUNT_W  = 32;
	localparam int MODE_W   = 2;

	// apb port
	localparam int PADDR_W  = 4;
	localparam int PDATA_W  = 32;
	localparam int REG_IDX_W = 2;

	localparam logic [HEAT_W-1:0] HEAT_FULL = 8'hFF;

	// item modes
	localparam logic [MODE_W-1:0] MODE_RECORD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DAMP   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;

	// register indexes
	localparam logic [REG_IDX_W-1:0] REG_RANGE_LOW   = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_RANGE_HIGH  = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_DAMP_PERIOD = 2'd2;

	// register reset values
	localparam logic signed [POS_W-1:0] RANGE_LOW_RST   = 32'sd0;
	localparam logic signed [POS_W-1:0] RANGE_HIGH_RST  = 32'sd65536;
	localparam logic [PERIOD_W-1:0]     DAMP_PERIOD_RST = 16'd500;

	typedef struct packed {
		logic [MODE_W-1:0]       mode;
		logic signed [POS_W-1:0] position;
		logic signed [TIME_W-1:0] now;
		logic [IDX_W-1:0]        segment_index;
	} item_t;

	typedef struct packed {
		logic                in_range;
		logic                was_hit;
		logic [HEAT_W-1:0]   heat_value;
		logic [COUNT_W-1:0]  access_total;
		logic [COUNT_W-1:0]  hit_total;
		logic                damped;
	} result_t;

	typedef struct packed {
		logic signed [POS_W-1:0] range_low;
		logic signed [POS_W-1:0] range_high;
		logic [PERIOD_W-1:0]     damp_period;
	} cfg_t;

	// one segment table entry
	typedef struct packed {
		logic              present;
		logic [HEAT_W-1:0] heat;
	} seg_entry_t;

endpackage

@@ rtl/ahfhe_ram.sv @@
module ahfhe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/ahfhe_div.sv @@
module ahfhe_div #(
	parameter int DIVIDEND_W = 41
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [31:0]           divisor,
	output logic                  done,
	output logic [DIVIDEND_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIVIDEND_W + 1);

	logic                  busy_q;
	logic                  done_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [31:0]           rem_q;
	logic [31:0]           divisor_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [32:0]           shifted;
	logic [33:0]           trial;
	logic                  fits;

	// one restoring step: shift in the next dividend bit, try to subtract
	assign shifted = {rem_q, quo_q[DIVIDEND_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor_q};
	assign fits    = ~trial[33];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVIDEND_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? trial[31:0] : shifted[31:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

@@ rtl/ahfhe_regs.sv @@
module ahfhe_regs import ahfhe_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] reg_idx;
	logic                 wr_en;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign wr_en   = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.range_low   <= RANGE_LOW_RST;
			cfg_q.range_high  <= RANGE_HIGH_RST;
			cfg_q.damp_period <= DAMP_PERIOD_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_RANGE_LOW:   cfg_q.range_low   <= pwdata;
				REG_RANGE_HIGH:  cfg_q.range_high  <= pwdata;
				REG_DAMP_PERIOD: cfg_q.damp_period <= pwdata[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_RANGE_LOW:   prdata = cfg_q.range_low;
			REG_RANGE_HIGH:  prdata = cfg_q.range_high;
			REG_DAMP_PERIOD: prdata = {{(PDATA_W-PERIOD_W){1'b0}}, cfg_q.damp_period};
			default:         prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/access_heatmap_fifo_hit_estimator.sv @@
// record beat: decode, abs, multiply, divide (bit-serial, one bit per cycle), check, look,
//   update, evict if the window is full; out of range skips look and update, empty range ends
//   after abs; damp beat that halves: decode, table sweep, one entry per cycle; read beat:
//   decode, read; other damp beats and unused mode: decode; a stalled output adds its stall
// one beat at a time; a finished result waits in the output register while the next beat enters
// after reset the segment table is swept to zero with item_stall high
module access_heatmap_fifo_hit_estimator import ahfhe_pkg::*; #(
	parameter int NUM_SEGMENTS = 256,
	parameter int WINDOW_DEPTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  item_t              item,
	output logic               result_valid,
	input  logic               result_stall,
	output result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	localparam int SEG_W  = $clog2(NUM_SEGMENTS);
	localparam int CNT_W  = $clog2(NUM_SEGMENTS + 1);
	localparam int PROD_W = POS_W + CNT_W;
	localparam int HEAD_W = $clog2(WINDOW_DEPTH);
	localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
	localparam int SUM_W  = FILL_W + 1;
	localparam int ENT_W  = $bits(seg_entry_t);

	typedef enum logic [13:0] {
		S_CLEAR = 14'b00000000000001,
		S_IDLE  = 14'b00000000000010,
		S_DEC   = 14'b00000000000100,
		S_ABS   = 14'b00000000001000,
		S_MUL   = 14'b00000000010000,
		S_START = 14'b00000000100000,
		S_DIV   = 14'b00000001000000,
		S_CHK   = 14'b00000010000000,
		S_LOOK  = 14'b00000100000000,
		S_UPD   = 14'b00001000000000,
		S_EVICT = 14'b00010000000000,
		S_DAMP  = 14'b00100000000000,
		S_HREAD = 14'b01000000000000,
		S_DONE  = 14'b10000000000000
	} state_t;

	state_t state_q;

	// configuration registers
	cfg_t cfg;

	ahfhe_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// captured beat and working registers
	item_t                   item_q;
	logic signed [POS_W:0]   diff_q;
	logic signed [POS_W:0]   den_q;
	logic [POS_W-1:0]        dmag_q;
	logic [POS_W-1:0]        nmag_q;
	logic                    neg_q;
	logic [PROD_W-1:0]       prod_q;
	logic [SEG_W-1:0]        seg_q;
	logic [SEG_W-1:0]        victim_q;
	logic [CNT_W-1:0]        cnt_q;

	// result fields being built
	logic                    in_range_q;
	logic                    hit_q;
	logic [HEAT_W-1:0]       heat_q;
	logic                    damped_q;

	// architectural state
	logic [COUNT_W-1:0]      access_q;
	logic [COUNT_W-1:0]      hits_q;
	logic signed [TIME_W-1:0] last_damp_q;
	logic [HEAD_W-1:0]       head_q;
	logic [FILL_W-1:0]       fill_q;

	// output register
	logic                    res_valid_q;
	result_t                 res_q;

	// divider
	logic                    div_start;
	logic                    div_done;
	logic [PROD_W-1:0]       quotient;

	ahfhe_div #(
		.DIVIDEND_W (PROD_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (prod_q),
		.divisor  (nmag_q),
		.done     (div_done),
		.quotient (quotient)
	);

	assign div_start = (state_q == S_START);

	// segment table: heat and present mark side by side
	logic                    seg_we;
	logic [SEG_W-1:0]        seg_waddr;
	seg_entry_t              seg_wdata;
	logic [SEG_W-1:0]        seg_raddr;
	seg_entry_t              seg_rdata;

	ahfhe_ram #(
		.WIDTH (ENT_W),
		.DEPTH (NUM_SEGMENTS)
	) u_seg_ram (
		.clk   (clk),
		.we    (seg_we),
		.waddr (seg_waddr),
		.wdata (seg_wdata),
		.raddr (seg_raddr),
		.rdata (seg_rdata)
	);

	// window of recent segments, oldest at head
	logic                    fifo_we;
	logic [HEAD_W-1:0]       fifo_waddr;
	logic [SEG_W-1:0]        fifo_rdata;

	ahfhe_ram #(
		.WIDTH (SEG_W),
		.DEPTH (WINDOW_DEPTH)
	) u_fifo_ram (
		.clk   (clk),
		.we    (fifo_we),
		.waddr (fifo_waddr),
		.wdata (seg_q),
		.raddr (head_q),
		.rdata (fifo_rdata)
	);

	// read-beat address, widened so any segment count fits
	logic [SEG_W+IDX_W-1:0]  idx_wide;
	logic                    idx_ok;

	assign idx_wide = {{SEG_W{1'b0}}, item_q.segment_index};
	assign idx_ok   = idx_wide < (SEG_W + IDX_W)'(NUM_SEGMENTS);

	// damp test on the exact signed time difference
	logic signed [TIME_W:0]  elapsed;
	logic                    damp_due;

	assign elapsed  = {item_q.now[TIME_W-1], item_q.now} - {last_damp_q[TIME_W-1], last_damp_q};
	assign damp_due = elapsed >= $signed({{(TIME_W+1-PERIOD_W){1'b0}}, cfg.damp_period});

	// quotient window check: zero, or positive and below the segment count
	logic                    quo_ok;

	assign quo_ok = (quotient == '0) || (!neg_q && (quotient < PROD_W'(NUM_SEGMENTS)));

	// window pointers
	logic                    win_full;
	logic [SUM_W-1:0]        tail_sum;
	logic [HEAD_W-1:0]       tail;
	logic [HEAD_W:0]         head_inc;
	logic [HEAD_W-1:0]       head_next;

	assign win_full  = (fill_q == FILL_W'(WINDOW_DEPTH));
	assign tail_sum  = SUM_W'(head_q) + SUM_W'(fill_q);
	assign tail      = (tail_sum >= SUM_W'(WINDOW_DEPTH)) ?
	                   HEAD_W'(tail_sum - SUM_W'(WINDOW_DEPTH)) : HEAD_W'(tail_sum);
	assign head_inc  = {1'b0, head_q} + 1'b1;
	assign head_next = (head_inc == (HEAD_W+1)'(WINDOW_DEPTH)) ? '0 : head_inc[HEAD_W-1:0];

	// damp sweep writes one entry behind the read
	logic [CNT_W-1:0]        cnt_prev;

	assign cnt_prev = cnt_q - 1'b1;

	logic                    out_free;

	assign out_free = !res_valid_q || !result_stall;

	// table port steering
	always_comb begin
		seg_we    = 1'b0;
		seg_waddr = seg_q;
		seg_wdata = '0;
		seg_raddr = seg_q;
		fifo_we   = 1'b0;
		fifo_waddr = win_full ? head_q : tail;
		unique case (state_q)
			S_CLEAR: begin
				seg_we    = 1'b1;
				seg_waddr = cnt_q[SEG_W-1:0];
			end
			S_DEC: begin
				seg_raddr = idx_wide[SEG_W-1:0];
			end
			S_UPD: begin
				// mark the segment hot and present, push it, fetch the victim's entry
				seg_we            = 1'b1;
				seg_wdata.present = 1'b1;
				seg_wdata.heat    = HEAT_FULL;
				seg_raddr         = fifo_rdata;
				fifo_we           = 1'b1;
			end
			S_EVICT: begin
				// victim loses its mark unless it is the segment just recorded
				seg_we            = (victim_q != seg_q);
				seg_waddr         = victim_q;
				seg_wdata.present = 1'b0;
				seg_wdata.heat    = seg_rdata.heat;
			end
			S_DAMP: begin
				seg_raddr         = cnt_q[SEG_W-1:0];
				seg_we            = (cnt_q != '0);
				seg_waddr         = cnt_prev[SEG_W-1:0];
				seg_wdata.present = seg_rdata.present;
				seg_wdata.heat    = seg_rdata.heat >> 1;
			end
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			cnt_q       <= '0;
			access_q    <= '0;
			hits_q      <= '0;
			last_damp_q <= '0;
			head_q      <= '0;
			fill_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (state_q == S_DONE && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && !result_stall) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_SEGMENTS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item_valid) begin
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					unique case (item_q.mode)
						MODE_RECORD: state_q <= S_ABS;
						MODE_DAMP: begin
							if (damp_due) begin
								last_damp_q <= item_q.now;
								cnt_q       <= '0;
								state_q     <= S_DAMP;
							end else begin
								state_q <= S_DONE;
							end
						end
						MODE_READ: state_q <= idx_ok ? S_HREAD : S_DONE;
						default:   state_q <= S_DONE;
					endcase
				end
				S_ABS: begin
					// empty range never maps anywhere
					state_q <= (den_q == '0) ? S_DONE : S_MUL;
				end
				S_MUL:   state_q <= S_START;
				S_START: state_q <= S_DIV;
				S_DIV: begin
					if (div_done) begin
						state_q <= S_CHK;
					end
				end
				S_CHK:  state_q <= quo_ok ? S_LOOK : S_DONE;
				S_LOOK: state_q <= S_UPD;
				S_UPD: begin
					access_q <= access_q + 1'b1;
					if (seg_rdata.present) begin
						hits_q <= hits_q + 1'b1;
					end
					if (win_full) begin
						head_q  <= head_next;
						state_q <= S_EVICT;
					end else begin
						fill_q  <= fill_q + 1'b1;
						state_q <= S_DONE;
					end
				end
				S_EVICT: state_q <= S_DONE;
				S_DAMP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_W'(NUM_SEGMENTS)) begin
						state_q <= S_DONE;
					end
				end
				S_HREAD: state_q <= S_DONE;
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				item_q     <= item;
				in_range_q <= 1'b0;
				hit_q      <= 1'b0;
				heat_q     <= '0;
				damped_q   <= 1'b0;
			end
			S_DEC: begin
				// exact 33-bit differences, no wrap
				diff_q <= {item_q.position[POS_W-1], item_q.position} -
				          {cfg.range_low[POS_W-1], cfg.range_low};
				den_q  <= {cfg.range_high[POS_W-1], cfg.range_high} -
				          {cfg.range_low[POS_W-1], cfg.range_low};
				if (item_q.mode == MODE_DAMP) begin
					damped_q <= damp_due;
				end
			end
			S_ABS: begin
				dmag_q <= diff_q[POS_W] ? POS_W'(-diff_q) : diff_q[POS_W-1:0];
				nmag_q <= den_q[POS_W] ? POS_W'(-den_q) : den_q[POS_W-1:0];
				neg_q  <= diff_q[POS_W] ^ den_q[POS_W];
			end
			S_MUL: begin
				prod_q <= {{CNT_W{1'b0}}, dmag_q} * PROD_W'(NUM_SEGMENTS);
			end
			S_CHK: begin
				seg_q      <= quotient[SEG_W-1:0];
				in_range_q <= quo_ok;
			end
			S_UPD: begin
				hit_q    <= seg_rdata.present;
				victim_q <= fifo_rdata;
			end
			S_HREAD: begin
				heat_q <= seg_rdata.heat;
			end
			S_DONE: begin
				if (out_free) begin
					res_q.in_range     <= in_range_q;
					res_q.was_hit      <= hit_q;
					res_q.heat_value   <= heat_q;
					res_q.access_total <= access_q;
					res_q.hit_total    <= hits_q;
					res_q.damped       <= damped_q;
				end
			end
			default: ;
		endcase
	end

	assign item_stall   = (state_q != S_IDLE);
	assign result_valid = res_valid_q;
	assign result       = res_q;

`ifndef NO_ASSERTIONS
	// access count moves only in the table update step
	a_access_step: assert property (@(posedge clk) disable iff (!arst_n)
		(access_q != $past(access_q)) |-> ($past(state_q) == S_UPD))
		else $error("access count changed outside table update");

	// a window hit is always also a counted access
	a_hit_with_access: assert property (@(posedge clk) disable iff (!arst_n)
		(hits_q != $past(hits_q)) |-> (access_q != $past(access_q)))
		else $error("hit counted without access");

	// window never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_DEPTH))
		else $error("window fill beyond depth");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV))
		else $error("divider done outside wait state");
`endif

endmodule

@@ tb/heatmap_check.sv @@
module heatmap_check import ahfhe_pkg::*; #(
	parameter int SEGMENTS = 256,
	parameter int WINDOW   = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	input  logic               item_stall,
	input  item_t              item,
	input  logic               result_valid,
	input  logic               result_stall,
	input  result_t            result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// register copies
	longint              span_lo;
	longint              span_hi;
	logic [PERIOD_W-1:0] halve_gap;

	// profiler state
	logic [HEAT_W-1:0]  heat_map [SEGMENTS];
	logic               in_window [SEGMENTS];
	int                 recent_seg [WINDOW];
	int                 recent_head;
	int                 recent_count;
	logic [COUNT_W-1:0] access_cnt;
	logic [COUNT_W-1:0] hit_cnt;
	longint             last_halving;

	result_t due_results [$];
	int      errs;
	int      beats_seen;

	function automatic result_t profile_step(item_t it);
		result_t r;
		longint  den;
		longint  num;
		longint  o;
		int      seg;
		r = '0;
		case (it.mode)
			MODE_RECORD: begin
				den = span_hi - span_lo;
				if (den != 0) begin
					num = (longint'($signed(it.position)) - span_lo) * SEGMENTS;
					o = num / den;
					if (o >= 0 && o < SEGMENTS) begin
						seg = int'(o);
						r.in_range = 1'b1;
						heat_map[seg] = HEAT_FULL;
						access_cnt++;
						if (in_window[seg]) begin
							hit_cnt++;
							r.was_hit = 1'b1;
						end
						// full window: drop the oldest segment and its mark
						if (recent_count >= WINDOW) begin
							in_window[recent_seg[recent_head]] = 1'b0;
							recent_head = (recent_head + 1) % WINDOW;
							recent_count--;
						end
						recent_seg[(recent_head + recent_count) % WINDOW] = seg;
						recent_count++;
						in_window[seg] = 1'b1;
					end
				end
			end
			MODE_DAMP: begin
				if (longint'($signed(it.now)) - last_halving >= longint'(halve_gap)) begin
					last_halving = longint'($signed(it.now));
					for (int i = 0; i < SEGMENTS; i++) heat_map[i] = heat_map[i] >> 1;
					r.damped = 1'b1;
				end
			end
			MODE_READ: begin
				if (int'(it.segment_index) < SEGMENTS) r.heat_value = heat_map[it.segment_index];
			end
			default: ;
		endcase
		r.access_total = access_cnt;
		r.hit_total    = hit_cnt;
		return r;
	endfunction

	function automatic void show(string tag, result_t r);
		$display("  %s in_range=%0b was_hit=%0b heat_value=%0d", tag, r.in_range, r.was_hit,
			r.heat_value);
		$display("  %s access_total=%0d hit_total=%0d damped=%0b", tag, r.access_total,
			r.hit_total, r.damped);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			span_lo      = longint'(RANGE_LOW_RST);
			span_hi      = longint'(RANGE_HIGH_RST);
			halve_gap    = DAMP_PERIOD_RST;
			for (int i = 0; i < SEGMENTS; i++) begin
				heat_map[i]  = '0;
				in_window[i] = 1'b0;
			end
			recent_head  = 0;
			recent_count = 0;
			access_cnt   = '0;
			hit_cnt      = '0;
			last_halving = 0;
			errs         = 0;
			beats_seen   = 0;
			due_results.delete();
			mismatches <= 0;
			pending    <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (paddr[REG_IDX_W+1:2])
					REG_RANGE_LOW:   span_lo = longint'($signed(pwdata));
					REG_RANGE_HIGH:  span_hi = longint'($signed(pwdata));
					REG_DAMP_PERIOD: halve_gap = pwdata[PERIOD_W-1:0];
					default: ;
				endcase
			end
			if (result_valid && !result_stall) begin
				beats_seen++;
				if (due_results.size() == 0) begin
					errs++;
					if (errs <= 10) begin
						$display("result beat %0d arrived with nothing owed", beats_seen);
						show("actual  ", result);
					end
				end else begin
					want = due_results[0];
					due_results.delete(0);
					if (result.in_range !== want.in_range || result.was_hit !== want.was_hit ||
							result.heat_value !== want.heat_value ||
							result.access_total !== want.access_total ||
							result.hit_total !== want.hit_total ||
							result.damped !== want.damped) begin
						errs++;
						if (errs <= 10) begin
							$display("result beat %0d mismatch", beats_seen);
							show("expected", want);
							show("actual  ", result);
						end
					end
				end
			end
			if (item_valid && !item_stall) begin
				due_results.insert(due_results.size(), profile_step(item));
			end
			mismatches <= errs;
			pending    <= due_results.size();
		end
	end

endmodule

@@ tb/tb.sv @@
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import ahfhe_pkg::*;

	localparam int SEGMENTS = 256;
	localparam int WINDOW   = 1024;
	// worst case is every beat a full damp walk behind long stalls, taken a few times over
	localparam int LIMIT    = 1_500_000;
	// a damp walk plus margin, waited out once the last result is in
	localparam int SETTLE   = 300;

	// codes the block does not use but that the stimulus must reach
	localparam logic [MODE_W-1:0]    MODE_SPARE = 2'd3;
	localparam logic [REG_IDX_W-1:0] REG_SPARE  = 2'd3;

	localparam longint POS_MIN = -64'sd2147483648;
	localparam longint POS_MAX = 64'sd2147483647;

	logic               clk          = 1'b0;
	logic               arst_n       = 1'b0;
	logic               item_valid   = 1'b0;
	logic               item_stall;
	item_t              item         = '0;
	logic               result_valid;
	logic               result_stall = 1'b0;
	result_t            result;
	logic               psel         = 1'b0;
	logic               penable      = 1'b0;
	logic               pwrite       = 1'b0;
	logic [PADDR_W-1:0] paddr        = '0;
	logic [PDATA_W-1:0] pwdata       = '0;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int mismatches;
	int pending;
	int cycles = 0;

	// stimulus-side view of the settings, used only to steer positions and time stamps
	longint cur_lo  = 0;
	longint cur_hi  = 65536;
	int     cur_per = 500;
	// last time stamp that halved the map, so damp beats can land on the period boundary
	longint stamp   = 0;
	// no idling on either side while set
	bit     quiet   = 1'b0;

	access_heatmap_fifo_hit_estimator #(
		.NUM_SEGMENTS(SEGMENTS),
		.WINDOW_DEPTH(WINDOW)
	) u_top (.*);

	heatmap_check #(
		.SEGMENTS(SEGMENTS),
		.WINDOW(WINDOW)
	) u_chk (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("tb failed");
			$finish;
		end
	end

	// receiver stalls at random, except during the quiet stretch
	always @(negedge clk) begin
		result_stall <= !quiet && ($urandom_range(99, 0) < 14);
	end

	// random fill for the fields a mode ignores
	function automatic item_t noise_item();
		item_t it;
		it.mode          = MODE_W'($urandom);
		it.position      = $urandom;
		it.now           = $urandom;
		it.segment_index = IDX_W'($urandom);
		return it;
	endfunction

	function automatic item_t record_beat(longint p);
		item_t it;
		it          = noise_item();
		it.mode     = MODE_RECORD;
		it.position = p[POS_W-1:0];
		return it;
	endfunction

	function automatic item_t read_beat(int idx);
		item_t it;
		it               = noise_item();
		it.mode          = MODE_READ;
		it.segment_index = IDX_W'(idx);
		return it;
	endfunction

	// also tracks the last halving time the block should hold
	function automatic item_t damp_beat(longint n);
		item_t  it;
		longint n32;
		it     = noise_item();
		it.mode = MODE_DAMP;
		it.now = n[TIME_W-1:0];
		n32    = longint'($signed(n[TIME_W-1:0]));
		if (n32 - stamp >= cur_per) stamp = n32;
		return it;
	endfunction

	// a position that maps into the segments; hot picks a few segments again and again
	function automatic longint span_pos(bit hot);
		longint d;
		longint mag;
		longint t;
		d   = cur_hi - cur_lo;
		mag = (d < 0) ? -d : d;
		if (mag == 0) return longint'(int'($urandom));
		if (hot) t = (longint'($urandom_range(7, 0) * 36) * mag + SEGMENTS - 1) / SEGMENTS;
		else t = longint'($urandom) % mag;
		return (d < 0) ? cur_lo - t : cur_lo + t;
	endfunction

	function automatic item_t rand_item();
		item_t             it;
		int                pick;
		logic [TIME_W-1:0] w;
		it   = noise_item();
		pick = $urandom_range(99, 0);
		if (pick < 90) begin
			pick = $urandom_range(99, 0);
			if (pick < 47) it = record_beat(span_pos(1'b1));
			else if (pick < 95) it = record_beat(span_pos(1'b0));
			else if (pick < 97) it = record_beat(cur_hi);
			else if (pick < 99) it = record_beat(cur_lo - 1);
			else it.mode = MODE_RECORD;
		end else if (pick < 94) begin
			pick = $urandom_range(99, 0);
			w    = $urandom;
			// positive noise stamps stay low so later halvings remain reachable
			if (!w[TIME_W-1]) w[TIME_W-2] = 1'b0;
			if (pick < 10) it = damp_beat(longint'($signed(w)));
			else if (pick < 25) it = damp_beat(stamp + cur_per - 1);
			else if (pick < 40) it = damp_beat(stamp + cur_per);
			else it = damp_beat(stamp + $urandom_range(2 * cur_per + 2, 0));
		end else if (pick < 98) begin
			it = read_beat($urandom_range(SEGMENTS - 1, 0));
		end else begin
			it.mode = MODE_SPARE;
		end
		return it;
	endfunction

	// one beat on the item channel, with random idle cycles ahead of it
	task automatic push_item(input item_t it);
		@(negedge clk);
		while (!quiet && $urandom_range(99, 0) < 14) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (item_stall);
	endtask

	// stop sending and wait until every owed result is in
	task automatic drain();
		@(negedge clk);
		item_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
	endtask

	// setup cycle, then access cycle until pready
	task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] val);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// registers change only with the block idle; the spare address must be ignored
	task automatic configure(input longint lo, input longint hi, input int per);
		drain();
		apb_write(REG_RANGE_LOW, lo[POS_W-1:0]);
		apb_write(REG_RANGE_HIGH, hi[POS_W-1:0]);
		apb_write(REG_DAMP_PERIOD, PDATA_W'(per));
		apb_write(REG_SPARE, $urandom);
		cur_lo  = longint'($signed(lo[POS_W-1:0]));
		cur_hi  = longint'($signed(hi[POS_W-1:0]));
		cur_per = per;
	endtask

	task automatic run_phase(input longint lo, input longint hi, input int per,
			input int count, input bit calm);
		configure(lo, hi, per);
		quiet = calm;
		repeat (count) push_item(rand_item());
		quiet = 1'b0;
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		// the block clears its segment table before taking beats
		do @(posedge clk); while (item_stall);

		// directed: default span, edges of the segment mapping
		configure(0, 65536, 500);
		push_item(read_beat(0));
		push_item(record_beat(0));
		push_item(record_beat(0));              // same segment again, now a window hit
		push_item(record_beat(65535));          // last segment
		push_item(record_beat(65536));          // exclusive upper end
		push_item(record_beat(-1));             // truncation toward zero lands in segment 0
		push_item(record_beat(-256));           // quotient -1
		push_item(record_beat(POS_MIN));
		push_item(record_beat(POS_MAX));
		push_item(read_beat(SEGMENTS - 1));
		push_item(damp_beat(499));              // one short of the period
		push_item(damp_beat(500));              // exactly the period
		push_item(damp_beat(POS_MIN));          // far in the past
		push_item(read_beat(0));
		push_item(noise_item());
		push_item(read_beat(200));
		// empty span and zero period
		configure(5, 5, 0);
		push_item(record_beat(5));
		push_item(damp_beat(500));
		// reversed span at the extremes, largest period
		configure(POS_MAX, POS_MIN, 65535);
		push_item(record_beat(POS_MAX));
		push_item(record_beat(POS_MIN));
		push_item(record_beat(0));
		push_item(damp_beat(stamp + 65534));
		push_item(damp_beat(stamp + 65535));

		// random: enough in-span records to fill the window and keep evicting
		run_phase(0, 256, 0, 260, 1'b0);
		run_phase(-1000, 3000, 65535, 260, 1'b1);
		run_phase(POS_MIN, POS_MAX, 1000, 220, 1'b0);
		run_phase(POS_MAX, POS_MIN, 500, 220, 1'b0);
		run_phase(longint'(int'($urandom)), longint'(int'($urandom)),
			$urandom_range(65535, 0), 200, 1'b0);
		run_phase(7, 7, 2, 50, 1'b0);
		run_phase(100000, -50, $urandom_range(65535, 0), 190, 1'b0);

		// latest possible time stamp, kept for the end since nothing halves after it
		push_item(damp_beat(POS_MAX));
		push_item(read_beat(SEGMENTS - 1));

		drain();
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && pending == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule

@@ access_heatmap_fifo_hit_estimator.f @@
rtl/ahfhe_pkg.sv
rtl/ahfhe_ram.sv
rtl/ahfhe_div.sv
rtl/ahfhe_regs.sv
rtl/access_heatmap_fifo_hit_estimator.sv
tb/heatmap_check.sv
tb/tb.sv
